[rtl/core/remq_pkg.sv]
// Shared constants, types and helper functions for the range extreme mismatch query unit.
// Used by the top level and by its port checker.
// No dependencies.
package remq_pkg;

  localparam int DEPTH       = 1024;
  localparam int LEVELS      = 11;
  localparam int VALUE_WIDTH = 20;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int ADDR_W = $clog2(LEVELS * DEPTH);
  localparam int SPAN_W = ((LEVELS > CNT_W) ? LEVELS : CNT_W) + 1;

  localparam int CMD_W      = 2;
  localparam int VAL_PORT_W = 20;
  localparam int POS_PORT_W = 11;
  localparam int STAT_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_BUILD  = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND        = 2'd0,
    ST_ALL_EXCLUDED = 2'd1,
    ST_BAD_RANGE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD_RD,
    S_BUILD_WR,
    S_QUERY
  } state_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] val;
    logic [IDX_W-1:0]       idx;
  } entry_t;

  function automatic entry_t pick_max(input entry_t a, input entry_t b);
    if (b.val > a.val || (b.val == a.val && b.idx < a.idx)) return b;
    return a;
  endfunction

  function automatic entry_t pick_min(input entry_t a, input entry_t b);
    if (b.val < a.val || (b.val == a.val && b.idx < a.idx)) return b;
    return a;
  endfunction

  function automatic logic [LVL_W-1:0] floor_log2(input logic [POS_PORT_W-1:0] len);
    logic [LVL_W-1:0] k;
    k = '0;
    for (int i = 1; i < POS_PORT_W; i++) begin
      if (len[i]) begin
        k = (i > LEVELS - 1) ? LVL_W'(LEVELS - 1) : LVL_W'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [ADDR_W-1:0] table_addr(input logic [LVL_W-1:0] lev,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(ADDR_W'(lev) * ADDR_W'(DEPTH)) + ADDR_W'(idx);
  endfunction

endpackage

[rtl/core/range_extreme_mismatch_query_unit.sv]
// Range extreme mismatch query unit: sparse min/max tables with a shared pick unit.
// Depends on remq_pkg.
//
// channel  | handshake          | word
// ---------+--------------------+-------------------------------------------------
// input    | in_valid, in_stall | command, value, left, right, excluded_value
// output   | out_valid,out_stall| position, status
//
// Append, unused command, or build over fewer than two entries: done in the idle state.
// Query: accept with the table read, then the shared pick unit fills the output register.
// Build: for each level L>=1 with 2^L <= count, each of its (count - 2^L + 1) entries
// takes a read state and a pick/write state through the table memory ports.
// Reset clears count, built flag and handshake state; tables need no clearing pass.
// A stalled output holds a finished query in its compare cycle; input stalls meanwhile.
module range_extreme_mismatch_query_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [remq_pkg::CMD_W-1:0]       command,
  input  logic [remq_pkg::VAL_PORT_W-1:0]  value,
  input  logic [remq_pkg::POS_PORT_W-1:0]  left,
  input  logic [remq_pkg::POS_PORT_W-1:0]  right,
  input  logic [remq_pkg::VAL_PORT_W-1:0]  excluded_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [remq_pkg::POS_PORT_W-1:0]  position,
  output logic [remq_pkg::STAT_W-1:0]      status
);
  import remq_pkg::*;

  state_t                 state, state_next;
  logic [LVL_W-1:0]       lev, lev_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   built, built_next;
  logic                   q_bad, q_bad_next;
  logic [VALUE_WIDTH-1:0] q_excl, q_excl_next;
  logic                   out_valid_next;
  logic [POS_PORT_W-1:0]  position_next;
  logic [STAT_W-1:0]      status_next;

  entry_t max_mem [LEVELS*DEPTH];
  entry_t min_mem [LEVELS*DEPTH];
  entry_t rd_max_a, rd_max_b, rd_min_a, rd_min_b;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
  entry_t            wr_max, wr_min;

  entry_t pk_max, pk_min;

  logic                  accept;
  logic [POS_PORT_W-1:0] q_len, q_span;
  logic [LVL_W-1:0]      q_lev;
  logic [IDX_W-1:0]      q_a, q_b;
  logic                  bad_in;

  logic [SPAN_W-1:0] b_span, cnt_ext;
  logic [IDX_W-1:0]  b_half;
  logic [LVL_W-1:0]  lev_m1;
  logic              more_idx, more_lev;
  logic [CNT_W-1:0]  base;
  logic              out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign q_len  = right - left + POS_PORT_W'(1);
  assign q_lev  = floor_log2(q_len);
  assign q_span = POS_PORT_W'(1) << q_lev;
  assign q_a    = IDX_W'(left - POS_PORT_W'(1));
  assign q_b    = IDX_W'(right - q_span);
  assign bad_in = !built || (left == '0) || (left > right) || (right > POS_PORT_W'(count));

  assign b_span   = SPAN_W'(1) << lev;
  assign b_half   = IDX_W'(b_span >> 1);
  assign lev_m1   = lev - LVL_W'(1);
  assign cnt_ext  = SPAN_W'(count);
  assign more_idx = (SPAN_W'(idx) + SPAN_W'(1) + b_span) <= cnt_ext;
  assign more_lev = (lev < LVL_W'(LEVELS - 1)) && ((b_span << 1) <= cnt_ext);

  assign pk_max = pick_max(rd_max_a, rd_max_b);
  assign pk_min = pick_min(rd_min_a, rd_min_b);

  assign out_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) max_mem[wr_addr] <= wr_max;
    if (rd_en) begin
      rd_max_a <= max_mem[rd_addr_a];
      rd_max_b <= max_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) min_mem[wr_addr] <= wr_min;
    if (rd_en) begin
      rd_min_a <= min_mem[rd_addr_a];
      rd_min_b <= min_mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      built     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      built     <= built_next;
      out_valid <= out_valid_next;
    end
    lev      <= lev_next;
    idx      <= idx_next;
    q_bad    <= q_bad_next;
    q_excl   <= q_excl_next;
    position <= position_next;
    status   <= status_next;
  end

  always_comb begin
    state_next     = state;
    lev_next       = lev;
    idx_next       = idx;
    count_next     = count;
    built_next     = built;
    q_bad_next     = q_bad;
    q_excl_next    = q_excl;
    out_valid_next = out_valid && out_stall;
    position_next  = position;
    status_next    = status;
    rd_en          = 1'b0;
    rd_addr_a      = table_addr(q_lev, q_a);
    rd_addr_b      = table_addr(q_lev, q_b);
    wr_en          = 1'b0;
    wr_addr        = table_addr(lev, idx);
    wr_max         = pk_max;
    wr_min         = pk_min;
    base           = built ? '0 : count;

    case (state)
      S_IDLE: begin
        rd_en = 1'b1;
        if (accept) begin
          case (command)
            CMD_APPEND: begin
              built_next = 1'b0;
              count_next = base;
              if (base < CNT_W'(DEPTH)) begin
                wr_en      = 1'b1;
                wr_addr    = table_addr('0, IDX_W'(base));
                wr_max     = '{val: value[VALUE_WIDTH-1:0], idx: IDX_W'(base)};
                wr_min     = '{val: value[VALUE_WIDTH-1:0], idx: IDX_W'(base)};
                count_next = base + CNT_W'(1);
              end
            end
            CMD_BUILD: begin
              if (LEVELS > 1 && count >= CNT_W'(2)) begin
                lev_next   = LVL_W'(1);
                idx_next   = '0;
                state_next = S_BUILD_RD;
              end else begin
                built_next = 1'b1;
              end
            end
            CMD_QUERY: begin
              q_bad_next  = bad_in;
              q_excl_next = excluded_value[VALUE_WIDTH-1:0];
              state_next  = S_QUERY;
            end
            default: begin
            end
          endcase
        end
      end
      S_BUILD_RD: begin
        rd_en      = 1'b1;
        rd_addr_a  = table_addr(lev_m1, idx);
        rd_addr_b  = table_addr(lev_m1, idx + b_half);
        state_next = S_BUILD_WR;
      end
      S_BUILD_WR: begin
        wr_en = 1'b1;
        if (more_idx) begin
          idx_next   = idx + IDX_W'(1);
          state_next = S_BUILD_RD;
        end else if (more_lev) begin
          lev_next   = lev + LVL_W'(1);
          idx_next   = '0;
          state_next = S_BUILD_RD;
        end else begin
          built_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_QUERY: begin
        if (out_load) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (q_bad) begin
            position_next = '0;
            status_next   = ST_BAD_RANGE;
          end else if (pk_max.val == pk_min.val && pk_max.val == q_excl) begin
            position_next = '0;
            status_next   = ST_ALL_EXCLUDED;
          end else if (pk_max.val == q_excl) begin
            position_next = POS_PORT_W'(pk_min.idx) + POS_PORT_W'(1);
            status_next   = ST_FOUND;
          end else begin
            position_next = POS_PORT_W'(pk_max.idx) + POS_PORT_W'(1);
            status_next   = ST_FOUND;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/remq_checker.sv]
// Port checker for the range extreme mismatch query unit, bound to the top level.
// Depends on remq_pkg and range_extreme_mismatch_query_unit.
module remq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [remq_pkg::CMD_W-1:0]       command,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [remq_pkg::POS_PORT_W-1:0]  position,
  input logic [remq_pkg::STAT_W-1:0]      status
);
  import remq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(status))
    else $error("stalled output word changed");

  a_found_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FOUND |-> position != '0)
    else $error("found status with zero position");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ALL_EXCLUDED || status == ST_BAD_RANGE) |-> position == '0)
    else $error("not-found status with nonzero position");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_QUERY |=> in_stall)
    else $error("query accepted without compare cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command != CMD_QUERY && !out_valid |=> !out_valid)
    else $error("output word without a query");

endmodule

bind range_extreme_mismatch_query_unit remq_checker u_remq_checker (.*);

[test/tb_range_extreme_mismatch_query_unit.sv]
// Self-checking bench for range_extreme_mismatch_query_unit: appends, table builds and
// range queries under random idling, checked word by word against an in-bench predictor.
// Depends on remq_pkg and the unit under test.
module tb_range_extreme_mismatch_query_unit;
  import remq_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;
  localparam int               CYCLE_LIMIT = 1_000_000;
  localparam int               HOLD_CYCLES = 300;

  typedef struct {
    logic [POS_PORT_W-1:0] position;
    status_t               status;
  } answer_t;

  class query_answer_book;
    logic [VALUE_WIDTH-1:0] held [1:DEPTH];
    int                     held_count = 0;
    bit                     tables_ready = 1'b0;
    answer_t                answers_due[$];
    int                     errors = 0;

    function void note_word(input logic [CMD_W-1:0] cmd, input logic [VAL_PORT_W-1:0] val,
                            input logic [POS_PORT_W-1:0] lo, input logic [POS_PORT_W-1:0] hi,
                            input logic [VAL_PORT_W-1:0] ex);
      answer_t                ans;
      logic [VALUE_WIDTH-1:0] top, bot, skip;
      int                     top_at, bot_at, i;
      skip = VALUE_WIDTH'(ex);
      case (cmd)
        CMD_APPEND: begin
          if (tables_ready) begin
            held_count   = 0;
            tables_ready = 1'b0;
          end
          if (held_count < DEPTH) begin
            held_count++;
            held[held_count] = VALUE_WIDTH'(val);
          end
        end
        CMD_BUILD: tables_ready = 1'b1;
        CMD_QUERY: begin
          ans.position = '0;
          ans.status   = ST_BAD_RANGE;
          if (tables_ready && lo >= 1 && lo <= hi && int'(hi) <= held_count) begin
            top    = held[lo];
            bot    = held[lo];
            top_at = lo;
            bot_at = lo;
            for (i = lo + 1; i <= int'(hi); i++) begin
              if (held[i] > top) begin
                top    = held[i];
                top_at = i;
              end
              if (held[i] < bot) begin
                bot    = held[i];
                bot_at = i;
              end
            end
            if (top == bot && top == skip) begin
              ans.status = ST_ALL_EXCLUDED;
            end else begin
              ans.status   = ST_FOUND;
              ans.position = POS_PORT_W'((top == skip) ? bot_at : top_at);
            end
          end
          answers_due.insert(answers_due.size(), ans);
        end
        default: ;
      endcase
    endfunction

    task report(input string what);
      if (errors < 30) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_answer(input logic [POS_PORT_W-1:0] pos, input logic [STAT_W-1:0] st);
      answer_t want;
      if (answers_due.size() == 0) begin
        report($sformatf("unexpected word position %0d status %0d", pos, st));
      end else begin
        want = answers_due.pop_front();
        if (pos !== want.position)
          report($sformatf("position %0d, want %0d", pos, want.position));
        if (st !== want.status)
          report($sformatf("status %0d, want %0d", st, want.status));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command = CMD_APPEND;
  logic [VAL_PORT_W-1:0] value = '0;
  logic [POS_PORT_W-1:0] left = '0;
  logic [POS_PORT_W-1:0] right = '0;
  logic [VAL_PORT_W-1:0] excluded_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_PORT_W-1:0] position;
  logic [STAT_W-1:0]     status;

  query_answer_book book = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int cycles = 0;
  bit hold_go = 1'b0;
  bit hold_off = 1'b0;

  range_extreme_mismatch_query_unit uut (
    .clk, .rst, .in_valid, .in_stall, .command, .value, .left, .right, .excluded_value,
    .out_valid, .out_stall, .position, .status
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_off || (int'($urandom_range(99)) < stall_pct);
  end

  // hold the output long enough for the unit to back up and stall its input
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_answer(position, status);
  end

  task automatic set_idle(input int snd, input int rcv);
    send_idle_pct = snd;
    stall_pct     = rcv;
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_PORT_W-1:0] val,
                           input logic [POS_PORT_W-1:0] lo, input logic [POS_PORT_W-1:0] hi,
                           input logic [VAL_PORT_W-1:0] ex);
    int gap;
    gap = 0;
    while (gap < 40 && int'($urandom_range(99)) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    command        <= cmd;
    value          <= val;
    left           <= lo;
    right          <= hi;
    excluded_value <= ex;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    book.note_word(cmd, val, lo, hi, ex);
    if (cmd != CMD_NOP) words_sent++;
    @(posedge clk);
  endtask

  task automatic send_append(input logic [VAL_PORT_W-1:0] val);
    send_word(CMD_APPEND, val, POS_PORT_W'($urandom), POS_PORT_W'($urandom),
              VAL_PORT_W'($urandom));
  endtask

  task automatic send_build();
    send_word(CMD_BUILD, VAL_PORT_W'($urandom), POS_PORT_W'($urandom), POS_PORT_W'($urandom),
              VAL_PORT_W'($urandom));
  endtask

  task automatic send_query(input int lo, input int hi, input logic [VAL_PORT_W-1:0] ex);
    send_word(CMD_QUERY, VAL_PORT_W'($urandom), POS_PORT_W'(lo), POS_PORT_W'(hi), ex);
  endtask

  task automatic append_run(input int n, input int style);
    logic [VAL_PORT_W-1:0] base;
    base = VAL_PORT_W'($urandom);
    repeat (n) begin
      case (style)
        0:       send_append(base);
        1:       send_append(base + VAL_PORT_W'($urandom_range(0, 2)));
        default: send_append(VAL_PORT_W'($urandom));
      endcase
    end
  endtask

  task automatic query_run(input int m);
    int                    lo, hi, pick;
    logic [VAL_PORT_W-1:0] ex;
    repeat (m) begin
      pick = $urandom_range(99);
      ex   = VAL_PORT_W'($urandom);
      if (book.held_count == 0 || pick < 12) begin
        lo = (pick < 3) ? 0 : $urandom_range(0, 2047);
        hi = pick[0] ? $urandom_range(0, 2047) : lo + $urandom_range(0, 3);
        if (pick < 6 && book.held_count > 0) begin
          lo = 1;
          hi = book.held_count + 1;
        end
      end else begin
        lo = $urandom_range(1, book.held_count);
        if (pick < 20) begin
          lo = 1;
          hi = book.held_count;
        end else if (pick < 60) begin
          hi = $urandom_range(lo, (lo + 7 < book.held_count) ? lo + 7 : book.held_count);
        end else begin
          hi = $urandom_range(lo, book.held_count);
        end
        if (pick % 10 < 7) ex = book.held[$urandom_range(lo, hi)];
      end
      send_query(lo, hi, ex);
    end
  endtask

  initial begin
    int target, roll, len, start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_idle(0, 0);
    send_query(1, 1, '0);
    send_build();
    send_query(1, 1, '0);
    send_append(20'hFFFFF);
    send_append(20'h00000);
    send_append(20'h00000);
    send_append(20'hFFFFF);
    send_append(20'h00007);
    send_query(1, 2, '0);
    send_build();
    send_query(0, 2, '0);
    send_query(3, 2, '0);
    send_query(1, 6, '0);
    send_query(2047, 2047, 20'hFFFFF);
    send_query(1, 5, 20'h00005);
    send_query(1, 5, 20'hFFFFF);
    send_query(2, 3, 20'h00000);
    send_query(5, 5, 20'h00007);
    send_query(5, 5, 20'h00000);
    send_query(4, 5, 20'hFFFFF);
    send_append(20'h00003);
    send_build();
    send_query(1, 1, 20'h00003);
    send_query(1, 5, 20'h00003);
    send_build();
    send_query(1, 1, 20'h00000);

    // fill past the array depth; the last two appends drop
    set_idle(20, 20);
    repeat (DEPTH + 2) send_append(VAL_PORT_W'($urandom_range(0, 15)));
    send_build();
    send_query(1, DEPTH, book.held[1]);
    send_query(1, DEPTH + 1, '0);
    send_query(DEPTH, DEPTH, book.held[DEPTH]);
    query_run(30);
    set_idle(0, 0);
    hold_go = 1'b1;
    query_run(40);

    start  = words_sent;
    target = (start + 300 > 1500) ? start + 300 : 1500;
    while (words_sent < target) begin
      case (((words_sent - start) * 4) / (target - start))
        0:       set_idle(0, 0);
        1:       set_idle(79, 0);
        2:       set_idle(0, 79);
        default: set_idle(20, 20);
      endcase
      roll = $urandom_range(99);
      if (roll < 80) begin
        len = (roll < 8) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        append_run(len, $urandom_range(0, 2));
        if (roll % 10 == 0) send_build();
        send_build();
        query_run($urandom_range(4, 20));
      end else begin
        repeat ($urandom_range(1, 5))
          send_word(CMD_W'($urandom_range(0, 3)), VAL_PORT_W'($urandom),
                    POS_PORT_W'($urandom), POS_PORT_W'($urandom), VAL_PORT_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    while (book.answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (book.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
